// ----- sv/ilha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilha_pkg
// Shared types and codes for the implicit-list heap allocator.
// ----------------------------------------------------------------------------
package ilha_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam int MIN_BLOCK = 16;

  // what called the grow/merge sequence
  typedef enum logic [1:0] {
    MODE_INIT,
    MODE_ALLOC,
    MODE_FREE
  } mode_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_INIT,
    ST_IDLE,
    ST_LV_RD,
    ST_LV_EV,
    ST_FR_W2,
    ST_SR_RD,
    ST_SR_EV,
    ST_G_CK,
    ST_G_W1,
    ST_G_W2,
    ST_G_W3,
    ST_M_R1,
    ST_M_R2,
    ST_M_R3,
    ST_M_R4,
    ST_M_R5,
    ST_M_R6,
    ST_M_W1,
    ST_M_W2,
    ST_M_P1,
    ST_M_P2,
    ST_M_P3,
    ST_M_END,
    ST_CV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] payload_addr;
    logic        status;
  } res_t;

endpackage

// ----- sv/implicit_list_heap_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_core
// Boundary-tag heap allocator, next-fit search, with merge on free and on grow.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                        | tuser
//  in_     | in  | [16:0] req_bytes, [32:17] block_addr | [0] cmd
//  out_    | out | [15:0] payload_addr          | [0] status
//
// Steps: allocate accepts the request, reads and checks each block header it
// visits (wrapping once to the start of the list), then makes 2 or 4 tag writes
// (4 on a split); growing adds a bounds check and three tag writes plus a merge,
// shortened when no neighbour is free. Free walks the block list from the start,
// clears the used bit in the header and footer tags, then runs the same merge.
// Reset: a clearing pass zeroes the tag memory, then the
// initial tags and first chunk are written; in_tready stays low meanwhile.
// Stalls: the result sits in an output register; a new request is taken while
// it waits, and the sequencer holds its next result until that slot frees.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator_core #(
  parameter int HEAP_BYTES  = 65536,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [16:0] req_bytes, [32:17] block_addr
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] payload_addr
  output logic [0:0]  out_tuser   // [0] status
);

  localparam int AB    = $clog2(HEAP_BYTES);
  localparam int W     = ((AB > 17) ? AB : 17) + 2;  // room for sums of sizes
  localparam int DEPTH = HEAP_BYTES / 4;
  localparam int IW    = $clog2(DEPTH);

  logic           mem_we, mem_re, res_valid, res_take;
  logic [IW-1:0]  mem_wi, mem_ri;
  logic [W-1:0]   mem_wd, mem_rd;
  ilha_pkg::res_t res;

  logic           out_valid_r;
  ilha_pkg::res_t out_r;

  // tag store: one word per 4 heap bytes
  ilha_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wi),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ri),
    .rdata (mem_rd)
  );

  ilha_seq #(
    .HEAP_BYTES  (HEAP_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES),
    .W           (W),
    .IW          (IW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_cmd   (in_tuser[0]),
    .req_bytes (in_tdata[16:0]),
    .req_addr  (in_tdata[32:17]),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_wi    (mem_wi),
    .mem_wd    (mem_wd),
    .mem_re    (mem_re),
    .mem_ri    (mem_ri),
    .mem_rd    (mem_rd)
  );

  // output slot takes a result when empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_r.payload_addr;
  assign out_tuser[0] = out_r.status;

endmodule

// ----- sv/ilha_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/ilha_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilha_seq
// Sequencer: clear pass, heap init, search, carve, grow, free and merge.
// ----------------------------------------------------------------------------
module ilha_seq #(
  parameter int HEAP_BYTES  = 65536,
  parameter int CHUNK_BYTES = 4096,
  parameter int W           = 19,
  parameter int IW          = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              req_cmd,
  input  logic [16:0]       req_bytes,
  input  logic [15:0]       req_addr,
  output logic              res_valid,
  input  logic              res_take,
  output ilha_pkg::res_t    res,
  output logic              mem_we,
  output logic [IW-1:0]     mem_wi,
  output logic [W-1:0]      mem_wd,
  output logic              mem_re,
  output logic [IW-1:0]     mem_ri,
  input  logic [W-1:0]      mem_rd
);

  localparam logic [W-1:0] HEAP_W  = W'(HEAP_BYTES);
  localparam logic [W-1:0] CHUNK_W = W'(CHUNK_BYTES);
  localparam logic [W-1:0] MINB    = W'(ilha_pkg::MIN_BLOCK);
  localparam logic [IW-1:0] LAST_I = IW'((HEAP_BYTES / 4) - 1);

  ilha_pkg::state_t state_r, state_nxt;
  ilha_pkg::mode_t  mode_r, mode_nxt;
  ilha_pkg::res_t   res_r, res_nxt;

  logic [W-1:0] bp_r, bp_nxt, need_r, need_nxt, sz_r, sz_nxt;
  logic [W-1:0] pv_r, pv_nxt, nx_r, nx_nxt, phsz_r, phsz_nxt;
  logic [W-1:0] top_r, top_nxt, wrap_r, wrap_nxt, spos_r, spos_nxt;
  logic [W-1:0] wa1_r, wa1_nxt, wa2_r, wa2_nxt;
  logic [15:0]  tgt_r, tgt_nxt;
  logic         pass_r, pass_nxt, pa_r, pa_nxt;
  logic [1:0]   step_r, step_nxt;
  logic [IW-1:0] clr_r, clr_nxt;

  logic [W-1:0] rsz, lim, ext, gsz, rest, s_pa, s_na, s_nn, need_in;
  logic         rused, split, fits, grow_ok;
  logic [W-1:0] wa, ra;

  function automatic logic [W-1:0] grow_size(input logic [W-1:0] e);
    grow_size = {e[W-1:3] + {{(W-4){1'b0}}, e[2]}, 3'b000};
  endfunction

  // datapath terms
  assign rsz     = {mem_rd[W-1:3], 3'b000};
  assign rused   = mem_rd[0];
  assign lim     = pass_r ? spos_r : top_r;
  assign ext     = (need_r > CHUNK_W) ? need_r : CHUNK_W;
  assign gsz     = grow_size(ext);
  assign rest    = sz_r - need_r;
  assign split   = rest >= MINB;
  assign fits    = (rsz >= need_r) && !rused;
  assign grow_ok = (top_r + sz_r) <= HEAP_W;
  assign s_pa    = sz_r + rsz;
  assign s_na    = sz_r + phsz_r;
  assign s_nn    = sz_r + phsz_r + rsz;
  assign need_in = (req_bytes > 17'd8) ?
                   ((W'(req_bytes) + W'(15)) & ~W'(7)) : MINB;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ilha_pkg::ST_CLR:   if (clr_r == LAST_I) state_nxt = ilha_pkg::ST_INIT;
      ilha_pkg::ST_INIT:  if (step_r == 2'd2) state_nxt = ilha_pkg::ST_G_CK;
      ilha_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_cmd == ilha_pkg::CMD_FREE) begin
            state_nxt = (req_addr == 16'd0) ? ilha_pkg::ST_DONE : ilha_pkg::ST_LV_RD;
          end else begin
            state_nxt = (req_bytes == 17'd0) ? ilha_pkg::ST_DONE : ilha_pkg::ST_SR_RD;
          end
        end
      end
      ilha_pkg::ST_LV_RD: state_nxt = (bp_r >= top_r) ? ilha_pkg::ST_DONE : ilha_pkg::ST_LV_EV;
      ilha_pkg::ST_LV_EV: begin
        if (rsz == '0 || W'(tgt_r) < bp_r) begin
          state_nxt = ilha_pkg::ST_DONE;
        end else if (W'(tgt_r) == bp_r) begin
          state_nxt = rused ? ilha_pkg::ST_FR_W2 : ilha_pkg::ST_DONE;
        end else begin
          state_nxt = ilha_pkg::ST_LV_RD;
        end
      end
      ilha_pkg::ST_FR_W2: state_nxt = ilha_pkg::ST_M_R1;
      ilha_pkg::ST_SR_RD: begin
        if (bp_r >= lim) begin
          if (pass_r) state_nxt = ilha_pkg::ST_G_CK;
        end else begin
          state_nxt = ilha_pkg::ST_SR_EV;
        end
      end
      ilha_pkg::ST_SR_EV: begin
        if (rsz == '0) begin
          state_nxt = pass_r ? ilha_pkg::ST_G_CK : ilha_pkg::ST_SR_RD;
        end else if (fits) begin
          state_nxt = ilha_pkg::ST_CV;
        end else begin
          state_nxt = ilha_pkg::ST_SR_RD;
        end
      end
      ilha_pkg::ST_G_CK: begin
        if (grow_ok) state_nxt = ilha_pkg::ST_G_W1;
        else if (mode_r == ilha_pkg::MODE_INIT) state_nxt = ilha_pkg::ST_IDLE;
        else state_nxt = ilha_pkg::ST_DONE;
      end
      ilha_pkg::ST_G_W1: state_nxt = ilha_pkg::ST_G_W2;
      ilha_pkg::ST_G_W2: state_nxt = ilha_pkg::ST_G_W3;
      ilha_pkg::ST_G_W3: state_nxt = ilha_pkg::ST_M_R1;
      ilha_pkg::ST_M_R1: state_nxt = ilha_pkg::ST_M_R2;
      ilha_pkg::ST_M_R2: state_nxt = ilha_pkg::ST_M_R3;
      ilha_pkg::ST_M_R3: state_nxt = ilha_pkg::ST_M_R4;
      ilha_pkg::ST_M_R4: state_nxt = ilha_pkg::ST_M_R5;
      ilha_pkg::ST_M_R5: state_nxt = ilha_pkg::ST_M_R6;
      ilha_pkg::ST_M_R6: state_nxt = (pa_r && rused) ? ilha_pkg::ST_M_END : ilha_pkg::ST_M_W1;
      ilha_pkg::ST_M_W1: state_nxt = ilha_pkg::ST_M_W2;
      ilha_pkg::ST_M_W2: state_nxt = ilha_pkg::ST_M_P1;
      ilha_pkg::ST_M_P1: state_nxt = ilha_pkg::ST_M_P2;
      ilha_pkg::ST_M_P2: state_nxt = ilha_pkg::ST_M_P3;
      ilha_pkg::ST_M_P3: state_nxt = ilha_pkg::ST_M_END;
      ilha_pkg::ST_M_END: begin
        unique case (mode_r)
          ilha_pkg::MODE_INIT:  state_nxt = ilha_pkg::ST_IDLE;
          ilha_pkg::MODE_ALLOC: state_nxt = ilha_pkg::ST_CV;
          default:              state_nxt = ilha_pkg::ST_DONE;
        endcase
      end
      ilha_pkg::ST_CV: if (step_r == (split ? 2'd3 : 2'd1)) state_nxt = ilha_pkg::ST_DONE;
      ilha_pkg::ST_DONE: if (res_take) state_nxt = ilha_pkg::ST_IDLE;
      default: state_nxt = ilha_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_nxt = mode_r;  res_nxt  = res_r;   bp_nxt   = bp_r;   need_nxt = need_r;
    sz_nxt   = sz_r;    pv_nxt   = pv_r;    nx_nxt   = nx_r;   phsz_nxt = phsz_r;
    top_nxt  = top_r;   wrap_nxt = wrap_r;  spos_nxt = spos_r; wa1_nxt  = wa1_r;
    wa2_nxt  = wa2_r;   tgt_nxt  = tgt_r;   pass_nxt = pass_r; pa_nxt   = pa_r;
    step_nxt = step_r;  clr_nxt  = clr_r;
    mem_we = 1'b0; wa = '0; mem_wd = '0; mem_re = 1'b0; ra = '0;
    req_ready = 1'b0; res_valid = 1'b0;
    unique case (state_r)
      ilha_pkg::ST_CLR: begin
        mem_we  = 1'b1;
        wa      = {{(W-IW-2){1'b0}}, clr_r, 2'b00};
        clr_nxt = clr_r + 1'b1;
        step_nxt = 2'd0;
      end
      ilha_pkg::ST_INIT: begin
        mem_we   = 1'b1;
        wa       = W'({step_r, 2'b00}) + W'(4);
        mem_wd   = (step_r == 2'd2) ? W'(1) : W'(9);
        step_nxt = step_r + 2'd1;
        top_nxt  = W'(16);
        wrap_nxt = W'(8);
        spos_nxt = W'(8);
        mode_nxt = ilha_pkg::MODE_INIT;
        sz_nxt   = grow_size(CHUNK_W);
      end
      ilha_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        res_nxt   = '0;
        tgt_nxt   = req_addr;
        bp_nxt    = (req_cmd == ilha_pkg::CMD_FREE) ? W'(8) : spos_r;
        need_nxt  = need_in;
        pass_nxt  = 1'b0;
        mode_nxt  = (req_cmd == ilha_pkg::CMD_FREE) ? ilha_pkg::MODE_FREE
                                                    : ilha_pkg::MODE_ALLOC;
        if (req_cmd == ilha_pkg::CMD_ALLOC && req_bytes == 17'd0) res_nxt.status = 1'b1;
      end
      ilha_pkg::ST_LV_RD: begin
        mem_re = 1'b1;
        ra     = bp_r - W'(4);
      end
      ilha_pkg::ST_LV_EV: begin
        sz_nxt = rsz;
        bp_nxt = bp_r + rsz;
        if (W'(tgt_r) == bp_r) begin
          bp_nxt = bp_r;
          mem_we = rused;
          wa     = bp_r - W'(4);
          mem_wd = rsz;
        end
      end
      ilha_pkg::ST_FR_W2: begin
        mem_we = 1'b1;
        wa     = bp_r + sz_r - W'(8);
        mem_wd = sz_r;
      end
      ilha_pkg::ST_SR_RD: begin
        if (bp_r >= lim) begin
          if (pass_r) begin
            sz_nxt = gsz;
          end else begin
            pass_nxt = 1'b1;
            bp_nxt   = wrap_r;
          end
        end else begin
          mem_re = 1'b1;
          ra     = bp_r - W'(4);
        end
      end
      ilha_pkg::ST_SR_EV: begin
        step_nxt = 2'd0;
        if (rsz == '0) begin
          if (pass_r) begin
            sz_nxt = gsz;
          end else begin
            pass_nxt = 1'b1;
            bp_nxt   = wrap_r;
          end
        end else if (fits) begin
          spos_nxt = bp_r;
          sz_nxt   = rsz;
        end else begin
          bp_nxt = bp_r + rsz;
        end
      end
      ilha_pkg::ST_G_CK: begin
        if (grow_ok) begin
          bp_nxt  = top_r;
          top_nxt = top_r + sz_r;
        end else begin
          res_nxt.status = 1'b1;
        end
      end
      ilha_pkg::ST_G_W1: begin
        mem_we = 1'b1; wa = bp_r - W'(4); mem_wd = sz_r;
      end
      ilha_pkg::ST_G_W2: begin
        mem_we = 1'b1; wa = bp_r + sz_r - W'(8); mem_wd = sz_r;
      end
      ilha_pkg::ST_G_W3: begin
        mem_we = 1'b1; wa = bp_r + sz_r - W'(4); mem_wd = W'(1);
      end
      ilha_pkg::ST_M_R1: begin
        mem_re = 1'b1; ra = bp_r - W'(8);
      end
      ilha_pkg::ST_M_R2: begin
        pv_nxt = bp_r - rsz;
        mem_re = 1'b1; ra = bp_r - W'(4);
      end
      ilha_pkg::ST_M_R3: begin
        sz_nxt = rsz;
        nx_nxt = bp_r + rsz;
        mem_re = 1'b1; ra = pv_r - W'(4);
      end
      ilha_pkg::ST_M_R4: begin
        phsz_nxt = rsz;
        mem_re = 1'b1; ra = pv_r + rsz - W'(8);
      end
      ilha_pkg::ST_M_R5: begin
        pa_nxt = rused;
        mem_re = 1'b1; ra = nx_r - W'(4);
      end
      ilha_pkg::ST_M_R6: begin
        if (pa_r && !rused) begin
          sz_nxt  = s_pa;
          wa1_nxt = bp_r - W'(4);
          wa2_nxt = bp_r + s_pa - W'(8);
        end else if (!pa_r && rused) begin
          sz_nxt  = s_na;
          wa1_nxt = bp_r + sz_r - W'(8);
          wa2_nxt = pv_r - W'(4);
          bp_nxt  = pv_r;
        end else if (!pa_r) begin
          sz_nxt  = s_nn;
          wa1_nxt = pv_r - W'(4);
          wa2_nxt = pv_r + s_nn - W'(8);
          bp_nxt  = pv_r;
        end
      end
      ilha_pkg::ST_M_W1: begin
        mem_we = 1'b1; wa = wa1_r; mem_wd = sz_r;
      end
      ilha_pkg::ST_M_W2: begin
        mem_we = 1'b1; wa = wa2_r; mem_wd = sz_r;
      end
      ilha_pkg::ST_M_P1: begin
        mem_re = 1'b1; ra = bp_r - W'(8);
      end
      ilha_pkg::ST_M_P2: begin
        mem_re = 1'b1; ra = bp_r - rsz - W'(4);
      end
      ilha_pkg::ST_M_P3: begin
        // block before the merged one is the prologue
        if (rsz < MINB) wrap_nxt = bp_r;
        if (spos_r > bp_r && spos_r < bp_r + sz_r) spos_nxt = bp_r;
      end
      ilha_pkg::ST_M_END: begin
        step_nxt = 2'd0;
      end
      ilha_pkg::ST_CV: begin
        mem_we   = 1'b1;
        step_nxt = step_r + 2'd1;
        res_nxt.payload_addr = bp_r[15:0];
        unique case (step_r)
          2'd0: begin
            wa = bp_r - W'(4);
            mem_wd = (split ? need_r : sz_r) | W'(1);
          end
          2'd1: begin
            wa = bp_r + (split ? need_r : sz_r) - W'(8);
            mem_wd = (split ? need_r : sz_r) | W'(1);
          end
          2'd2: begin
            wa = bp_r + need_r - W'(4);
            mem_wd = rest;
          end
          default: begin
            wa = bp_r + sz_r - W'(8);
            mem_wd = rest;
          end
        endcase
      end
      ilha_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign mem_wi = wa[IW+1:2];
  assign mem_ri = ra[IW+1:2];
  assign res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilha_pkg::ST_CLR;
      clr_r   <= '0;
      step_r  <= '0;
      mode_r  <= ilha_pkg::MODE_INIT;
      pass_r  <= 1'b0;
      top_r   <= W'(16);
      wrap_r  <= W'(8);
      spos_r  <= W'(8);
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      step_r  <= step_nxt;
      mode_r  <= mode_nxt;
      pass_r  <= pass_nxt;
      top_r   <= top_nxt;
      wrap_r  <= wrap_nxt;
      spos_r  <= spos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;  bp_r  <= bp_nxt;  need_r <= need_nxt; sz_r <= sz_nxt;
    pv_r   <= pv_nxt;   nx_r  <= nx_nxt;  phsz_r <= phsz_nxt; wa1_r <= wa1_nxt;
    wa2_r  <= wa2_nxt;  tgt_r <= tgt_nxt; pa_r   <= pa_nxt;
  end

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= HEAP_W) else $error("heap top beyond heap");
  a_top_align: assert property (@(posedge clk) disable iff (!rst_n)
    top_r[2:0] == 3'b000) else $error("heap top misaligned");
  a_pos_align: assert property (@(posedge clk) disable iff (!rst_n)
    spos_r[2:0] == 3'b000 && wrap_r[2:0] == 3'b000) else $error("search pointer misaligned");
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re)) else $error("read and write in one cycle");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !req_ready) else $error("request taken while result pending");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the implicit-list heap allocator core. A predictor
// keeps its own copy of the boundary-tag heap and computes each response; a
// driver streams requests, a monitor checks responses in order, and idle and
// stall patterns vary over the run, with one long receiver hold.
// ----------------------------------------------------------------------------
module tb;

  localparam int HEAP_B   = 65536;
  localparam int CHUNK_B  = 4096;
  localparam int WORDS    = HEAP_B / 4;
  localparam int N_RAND   = 1300;
  localparam int IDLE_MAX = 200000;

  typedef struct {
    logic        cmd;
    logic [16:0] req_bytes;
    logic [15:0] block_addr;
  } heap_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  implicit_list_heap_allocator_core #(
    .HEAP_BYTES (HEAP_B),
    .CHUNK_BYTES(CHUNK_B)
  ) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  int unsigned tag_mem [WORDS];
  int unsigned heap_end, wrap_bp, next_fit_bp;

  function automatic int unsigned tag_rd(int unsigned a);
    return ((a >> 2) < WORDS) ? tag_mem[a >> 2] : 0;
  endfunction

  function automatic void tag_wr(int unsigned a, int unsigned v);
    if ((a >> 2) < WORDS) tag_mem[a >> 2] = v;
  endfunction

  function automatic int unsigned tag_size(int unsigned a);
    return tag_rd(a) & ~32'd7;
  endfunction

  function automatic int unsigned tag_used(int unsigned a);
    return tag_rd(a) & 32'd1;
  endfunction

  function automatic int unsigned blk_prev(int unsigned bp);
    return bp - tag_size(bp - 8);
  endfunction

  function automatic int unsigned blk_next(int unsigned bp);
    return bp + tag_size(bp - 4);
  endfunction

  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned pv, nx, pa, na, sz;
    pv = blk_prev(bp);
    nx = blk_next(bp);
    pa = tag_used(pv + tag_size(pv - 4) - 8);
    na = tag_used(nx - 4);
    sz = tag_size(bp - 4);
    if (pa != 0 && na != 0) return bp;
    if (pa != 0) begin
      sz += tag_size(nx - 4);
      tag_wr(bp - 4, sz);
      tag_wr(bp + sz - 8, sz);
    end else if (na != 0) begin
      sz += tag_size(pv - 4);
      tag_wr(bp + tag_size(bp - 4) - 8, sz);
      tag_wr(pv - 4, sz);
      bp = pv;
    end else begin
      sz += tag_size(pv - 4) + tag_size(nx - 4);
      tag_wr(pv - 4, sz);
      tag_wr(pv + sz - 8, sz);
      bp = pv;
    end
    // merged block right after the prologue becomes the wrap start
    if (tag_size(blk_prev(bp) - 4) < ilha_pkg::MIN_BLOCK) wrap_bp = bp;
    if (next_fit_bp > bp && next_fit_bp < blk_next(bp)) next_fit_bp = bp;
    return bp;
  endfunction

  function automatic int unsigned grow_heap(int unsigned words);
    int unsigned sz, bp;
    sz = (words + (words & 1)) * 4;
    if (heap_end > HEAP_B || sz > HEAP_B - heap_end) return 0;
    bp = heap_end;
    heap_end += sz;
    tag_wr(bp - 4, sz);
    tag_wr(bp + sz - 8, sz);
    tag_wr(bp + sz - 4, 1);
    return coalesce(bp);
  endfunction

  function automatic bit fits(int unsigned bp, int unsigned need);
    return tag_size(bp - 4) >= need && tag_used(bp - 4) == 0;
  endfunction

  function automatic int unsigned scan_free(int unsigned need);
    int unsigned bp;
    for (bp = next_fit_bp; bp < heap_end && tag_size(bp - 4) > 0; bp = blk_next(bp))
      if (fits(bp, need)) begin
        next_fit_bp = bp;
        return bp;
      end
    for (bp = wrap_bp; bp < next_fit_bp && tag_size(bp - 4) > 0; bp = blk_next(bp))
      if (fits(bp, need)) begin
        next_fit_bp = bp;
        return bp;
      end
    return 0;
  endfunction

  function automatic void place(int unsigned bp, int unsigned need);
    int unsigned sz, rest;
    sz = tag_size(bp - 4);
    rest = sz - need;
    if (rest < ilha_pkg::MIN_BLOCK) begin
      tag_wr(bp - 4, sz | 1);
      tag_wr(bp + sz - 8, sz | 1);
    end else begin
      tag_wr(bp - 4, need | 1);
      tag_wr(bp + need - 8, need | 1);
      tag_wr(bp + need - 4, rest);
      tag_wr(bp + need + rest - 8, rest);
    end
  endfunction

  function automatic bit is_live(int unsigned target);
    int unsigned bp;
    for (bp = 8; bp < heap_end && tag_size(bp - 4) > 0; bp = blk_next(bp)) begin
      if (bp == target) return tag_used(bp - 4) != 0;
      if (bp > target) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic void heap_reset();
    foreach (tag_mem[i]) tag_mem[i] = 0;
    tag_wr(4, 9);
    tag_wr(8, 9);
    tag_wr(12, 1);
    heap_end = 16;
    wrap_bp = 8;
    next_fit_bp = 8;
    void'(grow_heap(CHUNK_B / 4));
  endfunction

  function automatic ilha_pkg::res_t heap_apply(heap_req_t r);
    ilha_pkg::res_t o;
    int unsigned need, ext, bp, sz;
    o = '0;
    if (r.cmd == ilha_pkg::CMD_FREE) begin
      if (r.block_addr != 0 && is_live(r.block_addr)) begin
        sz = tag_size(r.block_addr - 4);
        tag_wr(r.block_addr - 4, sz);
        tag_wr(r.block_addr + sz - 8, sz);
        void'(coalesce(r.block_addr));
      end
      return o;
    end
    if (r.req_bytes == 0) begin
      o.status = 1'b1;
      return o;
    end
    need = (r.req_bytes > 8) ? 8 * ((r.req_bytes + 15) / 8) : ilha_pkg::MIN_BLOCK;
    bp = scan_free(need);
    if (bp == 0) begin
      ext = (need > CHUNK_B) ? need : CHUNK_B;
      bp = grow_heap(ext / 4);
    end
    if (bp == 0) begin
      o.status = 1'b1;
      return o;
    end
    place(bp, need);
    o.payload_addr = bp[15:0];
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus
  heap_req_t      pending_reqs[$];
  ilha_pkg::res_t expected_resps[$];
  int unsigned    live_blocks[$];
  int unsigned    freed_blocks[$];
  int             n_alloc_ok, n_alloc_null, n_free;
  int             n_total, n_sent, n_checked, n_errors;

  task automatic queue_req(logic cmd, int unsigned req, int unsigned addr);
    heap_req_t      r;
    ilha_pkg::res_t o;
    int             idx[$];
    r.cmd = cmd;
    r.req_bytes = req[16:0];
    r.block_addr = addr[15:0];
    o = heap_apply(r);
    pending_reqs.push_back(r);
    expected_resps.push_back(o);
    if (cmd == ilha_pkg::CMD_FREE) begin
      n_free++;
      idx = live_blocks.find_first_index(x) with (x == addr);
      if (idx.size() != 0) begin
        live_blocks.delete(idx[0]);
        freed_blocks.push_back(addr);
      end
    end else if (o.status) n_alloc_null++;
    else begin
      n_alloc_ok++;
      live_blocks.push_back(o.payload_addr);
    end
  endtask

  task automatic free_live(int unsigned k);
    queue_req(ilha_pkg::CMD_FREE, 0, live_blocks[k % live_blocks.size()]);
  endtask

  // ---------------------------------------------------------------- driver
  logic in_acc = 1'b0;
  int   phase_idx;

  always @(posedge clk) in_acc <= in_tvalid && in_tready;

  always @(negedge clk) begin
    int pct;
    phase_idx = (n_total == 0) ? 0 : (n_sent * 5) / n_total;
    pct = (phase_idx == 1) ? 81 : (phase_idx == 3) ? 20 : 0;
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= pct) begin
        heap_req_t r;
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, r.block_addr, r.req_bytes};
        in_tuser  <= r.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) if (in_tvalid && in_tready) n_sent <= n_sent + 1;

  // receiver: stall pattern per phase plus one long hold-off
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    int pct, ph;
    ph = (n_total == 0) ? 0 : (n_sent * 5) / n_total;
    pct = (ph == 2) ? 81 : (ph == 3) ? 20 : 0;
    if (!hold_done && n_sent >= 400) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 500) hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= pct);
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH resp %0d %s: got %0d, expected %0d", n_checked, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    ilha_pkg::res_t want;
    if (out_tvalid && out_tready) begin
      if (expected_resps.size() == 0) begin
        report_mismatch("unexpected response", out_tdata, 0);
      end else begin
        want = expected_resps.pop_front();
        if (out_tdata !== want.payload_addr)
          report_mismatch("payload_addr", out_tdata, want.payload_addr);
        if (out_tuser[0] !== want.status)
          report_mismatch("status", out_tuser[0], want.status);
      end
      n_checked++;
    end
  end

  // watchdog: cycles in which neither channel moves anything
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= IDLE_MAX) begin
      $display("timeout: no traffic for %0d cycles", IDLE_MAX);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int unsigned k, sel, req;
    heap_reset();
    // directed corners
    queue_req(ilha_pkg::CMD_ALLOC, 0, 0);            // zero size
    queue_req(ilha_pkg::CMD_ALLOC, 1, 0);            // minimum block
    queue_req(ilha_pkg::CMD_ALLOC, 8, 0);
    queue_req(ilha_pkg::CMD_ALLOC, 9, 0);
    queue_req(ilha_pkg::CMD_ALLOC, 16, 0);
    queue_req(ilha_pkg::CMD_ALLOC, 65536, 0);        // bigger than the heap
    queue_req(ilha_pkg::CMD_ALLOC, 131071, 0);       // all request bits set
    queue_req(ilha_pkg::CMD_FREE, 0, 0);             // null free
    queue_req(ilha_pkg::CMD_FREE, 0, 12);            // not a payload
    queue_req(ilha_pkg::CMD_FREE, 0, 65535);
    queue_req(ilha_pkg::CMD_FREE, 0, live_blocks[1]);
    queue_req(ilha_pkg::CMD_FREE, 0, freed_blocks[0]);  // double free
    queue_req(ilha_pkg::CMD_ALLOC, 5000, 0);         // grows by request size
    queue_req(ilha_pkg::CMD_ALLOC, 4000, 0);
    while (live_blocks.size() != 0) free_live(0);  // merge everything back
    queue_req(ilha_pkg::CMD_ALLOC, 24, 0);
    queue_req(ilha_pkg::CMD_ALLOC, 40000, 0);        // fills most of the heap
    queue_req(ilha_pkg::CMD_ALLOC, 30000, 0);        // out of heap
    free_live(0);
    free_live(0);
    // random mix
    for (int i = 0; i < N_RAND; i++) begin
      sel = $urandom_range(99);
      if (sel < 55 || live_blocks.size() == 0) begin
        k = $urandom_range(99);
        if (k < 70) req = $urandom_range(256, 1);
        else if (k < 92) req = $urandom_range(4096, 257);
        else if (k < 97) req = $urandom_range(20000, 4097);
        else req = $urandom_range(131071);
        queue_req(ilha_pkg::CMD_ALLOC, req, 0);
      end else if (sel < 93) free_live($urandom);
      else if (sel < 96 && freed_blocks.size() != 0)
        queue_req(ilha_pkg::CMD_FREE, 0, freed_blocks[$urandom % freed_blocks.size()]);
      else if (sel < 98) queue_req(ilha_pkg::CMD_FREE, 0, $urandom_range(65535));
      else queue_req(ilha_pkg::CMD_ALLOC, 0, 0);
    end
    n_total = pending_reqs.size();

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pending_reqs.size() == 0 && expected_resps.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d requests: %0d allocations placed, %0d null, %0d frees",
             n_total, n_alloc_ok, n_alloc_null, n_free);
    $display("checked %0d responses across idle, stall and hold-off phases", n_checked);
    if (n_errors == 0 && expected_resps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- implicit_list_heap_allocator_core.f -----
sv/ilha_pkg.sv
sv/ilha_ram.sv
sv/ilha_seq.sv
sv/implicit_list_heap_allocator_core.sv
test/tb.sv
